// ----- hdl/swt_pkg.sv -----
// Shared constants and types for the shell word tokenizer.
package swt_pkg;

  localparam int ModeW = 4;

  localparam logic [ModeW-1:0] M_NORMAL      = 4'd0;
  localparam logic [ModeW-1:0] M_N_BSLASH    = 4'd1;
  localparam logic [ModeW-1:0] M_N_DOLLAR    = 4'd2;
  localparam logic [ModeW-1:0] M_SKIP_LF     = 4'd3;
  localparam logic [ModeW-1:0] M_SQUOTE      = 4'd4;
  localparam logic [ModeW-1:0] M_DQUOTE      = 4'd5;
  localparam logic [ModeW-1:0] M_DQ_BSLASH   = 4'd6;
  localparam logic [ModeW-1:0] M_ANSI        = 4'd7;
  localparam logic [ModeW-1:0] M_ANSI_BSLASH = 4'd8;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } swt_res_t;

  // results of one byte, handed from lexer to result buffer
  typedef struct packed {
    logic           load;
    logic [1:0]     nres;
    swt_res_t [2:0] res;
  } swt_batch_t;

endpackage

// ----- hdl/swt_if.sv -----
// Valid/ready channel interfaces for tokenizer input bytes and result beats.
interface swt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_command;

  modport source (output valid, output byte_in, output end_of_command, input ready);
  modport sink (input valid, input byte_in, input end_of_command, output ready);
endinterface

interface swt_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, output kind, output char_out, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input char_out, input last_of_run,
                output ready);
endinterface

// ----- hdl/shell_word_tokenizer.sv -----
// Top level of the streaming shell word tokenizer.
// Takes one command-line byte per beat and returns token characters and
// end-of-token markers, with last_of_run set on the final beat a byte causes.
// A byte is taken in the cycle it arrives whenever the result buffer is empty
// or sending its final beat, so while the receiver is ready, bytes that cause at most
// one result flow at one per cycle; a byte causing k results (k up to 3) sends them
// one after another through the single result port.
// Results appear in the cycle after their byte is taken.
module shell_word_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  swt_in_if.sink    in_chan,
  swt_out_if.source out_chan
);

  swt_pkg::swt_batch_t batch;
  logic                take;
  logic                accept;

  assign in_chan.ready = take;
  assign accept        = in_chan.valid & take;

  swt_lexer u_lexer (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .byte_in        (in_chan.byte_in),
    .end_of_command (in_chan.end_of_command),
    .batch          (batch)
  );

  swt_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .batch    (batch),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule

// ----- hdl/swt_lexer.sv -----
// Lexer state registers and next-state / result logic for one input byte.
module swt_lexer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             byte_in,
  input  logic                   end_of_command,
  output swt_pkg::swt_batch_t    batch
);

  typedef struct packed {
    logic [swt_pkg::ModeW-1:0] mode;
    logic                      chv;
    logic                      cls;
  } swt_unq_t;

  function automatic swt_unq_t unquoted(input logic [7:0] b, input logic eoc);
    swt_unq_t u;
    u.mode = swt_pkg::M_NORMAL;
    u.chv  = 1'b0;
    u.cls  = 1'b0;
    if (b inside {swt_pkg::CH_SP, swt_pkg::CH_TAB, swt_pkg::CH_CR, swt_pkg::CH_LF}) begin
      u.cls = 1'b1;
    end else if (b == swt_pkg::CH_SQUOTE) begin
      u.mode = swt_pkg::M_SQUOTE;
    end else if (b == swt_pkg::CH_DQUOTE) begin
      u.mode = swt_pkg::M_DQUOTE;
    end else if (b == swt_pkg::CH_BSLASH && !eoc) begin
      u.mode = swt_pkg::M_N_BSLASH;
    end else if (b == swt_pkg::CH_DOLLAR && !eoc) begin
      u.mode = swt_pkg::M_N_DOLLAR;
    end else begin
      u.chv = 1'b1;
    end
    return u;
  endfunction

  logic [swt_pkg::ModeW-1:0] mode_r;
  logic [swt_pkg::ModeW-1:0] mode_nxt;
  logic                      tok_r;
  logic                      tok_nxt;

  swt_unq_t   u;
  logic [1:0] nch;
  logic [7:0] c0;
  logic [7:0] c1;
  logic       cls;
  logic       tok1;
  logic       emit_cls;

  always_comb begin
    u        = unquoted(byte_in, end_of_command);
    mode_nxt = mode_r;
    nch      = 2'd0;
    c0       = byte_in;
    c1       = byte_in;
    cls      = 1'b0;
    case (mode_r)
      swt_pkg::M_N_BSLASH: begin
        if (byte_in == swt_pkg::CH_LF || byte_in == swt_pkg::CH_CR) begin
          mode_nxt = swt_pkg::M_SKIP_LF;
        end else begin
          nch      = 2'd1;
          mode_nxt = swt_pkg::M_NORMAL;
        end
      end
      swt_pkg::M_N_DOLLAR: begin
        if (byte_in == swt_pkg::CH_SQUOTE) begin
          mode_nxt = swt_pkg::M_ANSI;
        end else begin
          c0       = swt_pkg::CH_DOLLAR;
          nch      = u.chv ? 2'd2 : 2'd1;
          mode_nxt = u.mode;
          cls      = u.cls;
        end
      end
      swt_pkg::M_SKIP_LF: begin
        if (byte_in == swt_pkg::CH_LF) begin
          mode_nxt = swt_pkg::M_NORMAL;
        end else begin
          nch      = {1'b0, u.chv};
          mode_nxt = u.mode;
          cls      = u.cls;
        end
      end
      swt_pkg::M_SQUOTE: begin
        if (byte_in == swt_pkg::CH_SQUOTE) begin
          mode_nxt = swt_pkg::M_NORMAL;
        end else begin
          nch = 2'd1;
        end
      end
      swt_pkg::M_DQUOTE: begin
        if (byte_in == swt_pkg::CH_DQUOTE) begin
          mode_nxt = swt_pkg::M_NORMAL;
        end else if (byte_in == swt_pkg::CH_BSLASH && !end_of_command) begin
          mode_nxt = swt_pkg::M_DQ_BSLASH;
        end else begin
          nch = 2'd1;
        end
      end
      swt_pkg::M_DQ_BSLASH: begin
        mode_nxt = swt_pkg::M_DQUOTE;
        nch      = 2'd1;
        if (byte_in == swt_pkg::CH_N) begin
          c0 = swt_pkg::CH_LF;
        end else if (byte_in == swt_pkg::CH_T) begin
          c0 = swt_pkg::CH_TAB;
        end else if (byte_in == swt_pkg::CH_DQUOTE || byte_in == swt_pkg::CH_BSLASH) begin
          c0 = byte_in;
        end else begin
          c0  = swt_pkg::CH_BSLASH;
          nch = 2'd2;
        end
      end
      swt_pkg::M_ANSI: begin
        if (byte_in == swt_pkg::CH_SQUOTE) begin
          mode_nxt = swt_pkg::M_NORMAL;
        end else if (byte_in == swt_pkg::CH_BSLASH && !end_of_command) begin
          mode_nxt = swt_pkg::M_ANSI_BSLASH;
        end else begin
          nch = 2'd1;
        end
      end
      swt_pkg::M_ANSI_BSLASH: begin
        mode_nxt = swt_pkg::M_ANSI;
        nch      = 2'd1;
        if (byte_in == swt_pkg::CH_N) begin
          c0 = swt_pkg::CH_LF;
        end else if (byte_in == swt_pkg::CH_T) begin
          c0 = swt_pkg::CH_TAB;
        end else if (byte_in == swt_pkg::CH_R) begin
          c0 = swt_pkg::CH_CR;
        end else if (byte_in == swt_pkg::CH_BSLASH || byte_in == swt_pkg::CH_SQUOTE ||
                     byte_in == swt_pkg::CH_DQUOTE) begin
          c0 = byte_in;
        end else begin
          c0  = swt_pkg::CH_BSLASH;
          nch = 2'd2;
        end
      end
      default: begin
        nch      = {1'b0, u.chv};
        mode_nxt = u.mode;
        cls      = u.cls;
      end
    endcase

    if (end_of_command) begin
      mode_nxt = swt_pkg::M_NORMAL;
      cls      = 1'b1;
    end

    // characters always precede the end marker
    tok1     = tok_r | (nch != 2'd0);
    emit_cls = cls & tok1;
    tok_nxt  = cls ? 1'b0 : tok1;

    batch.load        = accept;
    batch.nres        = nch + {1'b0, emit_cls};
    batch.res[0].kind = (nch != 2'd0) ? swt_pkg::KIND_CHAR : swt_pkg::KIND_END;
    batch.res[0].ch   = (nch != 2'd0) ? c0 : 8'd0;
    batch.res[1].kind = (nch == 2'd2) ? swt_pkg::KIND_CHAR : swt_pkg::KIND_END;
    batch.res[1].ch   = (nch == 2'd2) ? c1 : 8'd0;
    batch.res[2].kind = swt_pkg::KIND_END;
    batch.res[2].ch   = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= swt_pkg::M_NORMAL;
      tok_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      tok_r  <= tok_nxt;
    end
  end

endmodule

// ----- hdl/swt_emit.sv -----
// Result buffer: holds the beats of one byte and sends them one per cycle while the receiver is ready.
module swt_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  swt_pkg::swt_batch_t batch,
  output logic                take,
  swt_out_if.source           out_chan
);

  swt_pkg::swt_res_t [2:0] res_r;
  logic [1:0]              cnt_r;
  logic [1:0]              pos_r;
  logic [1:0]              pos_nxt;
  swt_pkg::swt_res_t       cur;
  logic                    last;
  logic                    beat;

  always_comb begin
    case (pos_r)
      2'd0:    cur = res_r[0];
      2'd1:    cur = res_r[1];
      2'd2:    cur = res_r[2];
      default: cur = res_r[2];
    endcase
  end

  assign pos_nxt              = pos_r + 2'd1;
  assign last                 = (pos_nxt == cnt_r);
  assign out_chan.valid       = (pos_r != cnt_r);
  assign out_chan.kind        = cur.kind;
  assign out_chan.char_out    = cur.ch;
  assign out_chan.last_of_run = last;
  assign beat                 = out_chan.valid & out_chan.ready;
  // free when empty or once the final beat of the buffered byte leaves
  assign take                 = !out_chan.valid | (out_chan.ready & last);

  always_ff @(posedge clk) begin
    if (batch.load) begin
      res_r <= batch.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      pos_r <= 2'd0;
    end else if (batch.load) begin
      cnt_r <= batch.nres;
      pos_r <= 2'd0;
    end else if (beat) begin
      pos_r <= pos_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= cnt_r)
    else $error("result position past count");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (batch.load && batch.nres != 2'd0) |=> out_chan.valid)
    else $error("loaded results not presented");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !last && !batch.load) |=> out_chan.valid)
    else $error("run dropped before its last beat");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    batch.load |-> take)
    else $error("byte loaded over pending results");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == swt_pkg::KIND_END) |-> out_chan.char_out == 8'd0)
    else $error("end marker with nonzero char");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the shell word tokenizer: directed quoting cases plus random commands.
module testbench;

  localparam int RANDOM_BYTES = 420;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } tok_beat_t;

  typedef struct {
    logic [7:0] b;
    logic       eoc;
    bit         calm;
    bit         drain;
  } send_item_t;

  logic clk = 1'b0;
  logic rst_n;

  swt_in_if  in_chan ();
  swt_out_if out_chan ();

  shell_word_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // lexer state mirror
  logic [swt_pkg::ModeW-1:0] scan_mode;
  logic                      word_open;
  tok_beat_t                 step_beats[$];
  tok_beat_t                 beats_due[$];

  send_item_t bytes_to_send[$];
  logic [7:0] cmd_buf[$];

  int  total_bytes;
  int  cmd_count;
  int  bytes_taken;
  int  beats_seen;
  int  errs;
  int  cycle;
  int  gap_left;
  int  stall_left;
  bit  send_now;
  bit  take;
  bit  hold_rx;
  bit  rx_calm;
  send_item_t nxt;
  tok_beat_t  want;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------- token predictor ----------------
  function automatic void emit_beat(input logic kind, input logic [7:0] ch);
    if (step_beats.size() < 3) begin
      step_beats.insert(step_beats.size(), '{kind, ch, 1'b0});
    end
  endfunction

  function automatic void add_char(input logic [7:0] ch);
    emit_beat(swt_pkg::KIND_CHAR, ch);
    word_open = 1'b1;
  endfunction

  function automatic void close_word();
    if (word_open) begin
      emit_beat(swt_pkg::KIND_END, 8'h00);
    end
    word_open = 1'b0;
  endfunction

  function automatic void plain_byte(input logic [7:0] b, input logic eoc);
    scan_mode = swt_pkg::M_NORMAL;
    if (b == swt_pkg::CH_SP || b == swt_pkg::CH_TAB || b == swt_pkg::CH_CR ||
        b == swt_pkg::CH_LF) begin
      close_word();
    end else if (b == swt_pkg::CH_SQUOTE) begin
      scan_mode = swt_pkg::M_SQUOTE;
    end else if (b == swt_pkg::CH_DQUOTE) begin
      scan_mode = swt_pkg::M_DQUOTE;
    end else if (b == swt_pkg::CH_BSLASH && !eoc) begin
      scan_mode = swt_pkg::M_N_BSLASH;
    end else if (b == swt_pkg::CH_DOLLAR && !eoc) begin
      scan_mode = swt_pkg::M_N_DOLLAR;
    end else begin
      add_char(b);
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic eoc);
    step_beats.delete();
    case (scan_mode)
      swt_pkg::M_N_BSLASH: begin
        if (b == swt_pkg::CH_LF || b == swt_pkg::CH_CR) begin
          scan_mode = swt_pkg::M_SKIP_LF;
        end else begin
          add_char(b);
          scan_mode = swt_pkg::M_NORMAL;
        end
      end
      swt_pkg::M_N_DOLLAR: begin
        if (b == swt_pkg::CH_SQUOTE) begin
          scan_mode = swt_pkg::M_ANSI;
        end else begin
          add_char(swt_pkg::CH_DOLLAR);
          plain_byte(b, eoc);
        end
      end
      swt_pkg::M_SKIP_LF: begin
        scan_mode = swt_pkg::M_NORMAL;
        if (b != swt_pkg::CH_LF) begin
          plain_byte(b, eoc);
        end
      end
      swt_pkg::M_SQUOTE: begin
        if (b == swt_pkg::CH_SQUOTE) begin
          scan_mode = swt_pkg::M_NORMAL;
        end else begin
          add_char(b);
        end
      end
      swt_pkg::M_DQUOTE: begin
        if (b == swt_pkg::CH_DQUOTE) begin
          scan_mode = swt_pkg::M_NORMAL;
        end else if (b == swt_pkg::CH_BSLASH && !eoc) begin
          scan_mode = swt_pkg::M_DQ_BSLASH;
        end else begin
          add_char(b);
        end
      end
      swt_pkg::M_DQ_BSLASH: begin
        scan_mode = swt_pkg::M_DQUOTE;
        if (b == swt_pkg::CH_N) begin
          add_char(swt_pkg::CH_LF);
        end else if (b == swt_pkg::CH_T) begin
          add_char(swt_pkg::CH_TAB);
        end else if (b == swt_pkg::CH_DQUOTE || b == swt_pkg::CH_BSLASH) begin
          add_char(b);
        end else begin
          add_char(swt_pkg::CH_BSLASH);
          add_char(b);
        end
      end
      swt_pkg::M_ANSI: begin
        if (b == swt_pkg::CH_SQUOTE) begin
          scan_mode = swt_pkg::M_NORMAL;
        end else if (b == swt_pkg::CH_BSLASH && !eoc) begin
          scan_mode = swt_pkg::M_ANSI_BSLASH;
        end else begin
          add_char(b);
        end
      end
      swt_pkg::M_ANSI_BSLASH: begin
        scan_mode = swt_pkg::M_ANSI;
        if (b == swt_pkg::CH_N) begin
          add_char(swt_pkg::CH_LF);
        end else if (b == swt_pkg::CH_T) begin
          add_char(swt_pkg::CH_TAB);
        end else if (b == swt_pkg::CH_R) begin
          add_char(swt_pkg::CH_CR);
        end else if (b == swt_pkg::CH_BSLASH || b == swt_pkg::CH_SQUOTE ||
                     b == swt_pkg::CH_DQUOTE) begin
          add_char(b);
        end else begin
          add_char(swt_pkg::CH_BSLASH);
          add_char(b);
        end
      end
      default: begin
        plain_byte(b, eoc);
      end
    endcase
    if (eoc) begin
      close_word();
      scan_mode = swt_pkg::M_NORMAL;
    end
    if (step_beats.size() > 0) begin
      step_beats[step_beats.size() - 1].last = 1'b1;
    end
    foreach (step_beats[i]) beats_due.insert(beats_due.size(), step_beats[i]);
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic void add_byte(input logic [7:0] c);
    cmd_buf.insert(cmd_buf.size(), c);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == swt_pkg::CH_DQUOTE || c == swt_pkg::CH_DOLLAR || c == swt_pkg::CH_SQUOTE ||
        c == swt_pkg::CH_BSLASH) begin
      c = 8'h5F;
    end
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(input logic [7:0] stop_ch);
    logic [7:0] c;
    c = 8'($urandom);
    if (c == stop_ch || c == swt_pkg::CH_BSLASH) begin
      c = 8'h71;
    end
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = swt_pkg::CH_SP;
      1: c = swt_pkg::CH_TAB;
      2: c = swt_pkg::CH_CR;
      default: c = swt_pkg::CH_LF;
    endcase
    return c;
  endfunction

  function automatic void add_piece();
    int n;
    n = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat (n + 1) add_byte(word_char());
      end
      3: begin
        add_byte(swt_pkg::CH_SQUOTE);
        repeat (n) add_byte(quoted_char(swt_pkg::CH_SQUOTE));
        add_byte(swt_pkg::CH_SQUOTE);
      end
      4: begin
        add_byte(swt_pkg::CH_DQUOTE);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            add_byte(swt_pkg::CH_BSLASH);
            case ($urandom_range(0, 4))
              0: add_byte(swt_pkg::CH_N);
              1: add_byte(swt_pkg::CH_T);
              2: add_byte(swt_pkg::CH_DQUOTE);
              3: add_byte(swt_pkg::CH_BSLASH);
              default: add_byte(8'($urandom));
            endcase
          end else begin
            add_byte(quoted_char(swt_pkg::CH_DQUOTE));
          end
        end
        add_byte(swt_pkg::CH_DQUOTE);
      end
      5: begin
        add_byte(swt_pkg::CH_DOLLAR);
        add_byte(swt_pkg::CH_SQUOTE);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            add_byte(swt_pkg::CH_BSLASH);
            case ($urandom_range(0, 6))
              0: add_byte(swt_pkg::CH_N);
              1: add_byte(swt_pkg::CH_T);
              2: add_byte(swt_pkg::CH_R);
              3: add_byte(swt_pkg::CH_BSLASH);
              4: add_byte(swt_pkg::CH_SQUOTE);
              5: add_byte(swt_pkg::CH_DQUOTE);
              default: add_byte(8'($urandom));
            endcase
          end else begin
            add_byte(quoted_char(swt_pkg::CH_SQUOTE));
          end
        end
        add_byte(swt_pkg::CH_SQUOTE);
      end
      6: begin
        add_byte(swt_pkg::CH_BSLASH);
        add_byte(8'($urandom));
      end
      7: begin
        // line continuation, sometimes CR LF
        add_byte(swt_pkg::CH_BSLASH);
        add_byte($urandom_range(0, 1) ? swt_pkg::CH_CR : swt_pkg::CH_LF);
        if ($urandom_range(0, 1)) begin
          add_byte(swt_pkg::CH_LF);
        end
      end
      8: begin
        add_byte(swt_pkg::CH_DOLLAR);
        add_byte($urandom_range(0, 1) ? word_char() : quoted_char(swt_pkg::CH_SQUOTE));
      end
      default: begin
        add_byte(8'($urandom));
      end
    endcase
  endfunction

  function automatic void flush_cmd(input bit calm, input bit cut);
    int stop;
    stop = cut ? $urandom_range(0, cmd_buf.size() - 1) : cmd_buf.size() - 1;
    for (int i = 0; i <= stop; i++) begin
      bytes_to_send.insert(bytes_to_send.size(), '{cmd_buf[i], i == stop, calm, 1'b0});
    end
    total_bytes += stop + 1;
    cmd_count++;
    cmd_buf.delete();
  endfunction

  function automatic void add_drain();
    bytes_to_send.insert(bytes_to_send.size(), '{8'h00, 1'b0, 1'b0, 1'b1});
  endfunction

  function automatic void build_random_cmd();
    int words;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end else begin
      words = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) begin
        add_byte(blank_char());
      end
      for (int w = 0; w < words; w++) begin
        if (w > 0) begin
          repeat ($urandom_range(1, 2)) add_byte(blank_char());
        end
        repeat ($urandom_range(1, 3)) add_piece();
      end
    end
    flush_cmd($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        tokenize_byte(in_chan.byte_in, in_chan.end_of_command);
        bytes_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        send_now = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (bytes_to_send.size() > 0) begin
          if (bytes_to_send[0].drain) begin
            if (beats_due.size() == 0) begin
              void'(bytes_to_send.pop_front());
            end
          end else begin
            nxt = bytes_to_send.pop_front();
            in_chan.byte_in        <= nxt.b;
            in_chan.end_of_command <= nxt.eoc;
            send_now = 1'b1;
            gap_left = nxt.calm ? 0 : $urandom_range(0, 3);
          end
        end
        in_chan.valid <= send_now;
      end
    end
  end

  // ---------------- monitor / checker ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        beats_seen++;
        if (beats_due.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected beat %0d: kind=%0b char=%02h last=%0b", beats_seen,
                     out_chan.kind, out_chan.char_out, out_chan.last_of_run);
          end
        end else begin
          want = beats_due.pop_front();
          if (out_chan.kind !== want.kind || out_chan.char_out !== want.ch ||
              out_chan.last_of_run !== want.last) begin
            errs++;
            if (errs <= 10) begin
              $display("beat %0d mismatch: exp kind=%0b char=%02h last=%0b,",
                       beats_seen, want.kind, want.ch, want.last);
              $display("  got kind=%0b char=%02h last=%0b",
                       out_chan.kind, out_chan.char_out, out_chan.last_of_run);
            end
          end
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_chan.ready <= take && !hold_rx;
    end
  end

  // cycle count, long receiver hold-off, calm windows, timeout
  always @(posedge clk) begin
    cycle   <= cycle + 1;
    rx_calm <= (cycle % 512) < 128;
    if (cycle == HOLD_AT) begin
      hold_rx <= 1'b1;
    end else if (cycle == HOLD_AT + HOLD_LEN) begin
      hold_rx <= 1'b0;
    end
    if (cycle == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle, beats_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.byte_in        = 8'h00;
    in_chan.end_of_command = 1'b0;
    out_chan.ready         = 1'b0;
    scan_mode              = swt_pkg::M_NORMAL;
    word_open              = 1'b0;
    cycle                  = 0;
    hold_rx                = 1'b0;
    rx_calm                = 1'b0;
    total_bytes            = 0;
    cmd_count              = 0;
    bytes_taken            = 0;
    beats_seen             = 0;
    errs                   = 0;

    // extreme bytes, empty quotes, unknown escape, dollar without quote,
    // continuation eating LF, trailing backslash
    cmd_buf = '{8'h00, 8'hFF, swt_pkg::CH_TAB, swt_pkg::CH_DQUOTE, swt_pkg::CH_DQUOTE,
                swt_pkg::CH_SP, swt_pkg::CH_DQUOTE, swt_pkg::CH_BSLASH, 8'h71,
                swt_pkg::CH_DQUOTE, swt_pkg::CH_DOLLAR, 8'h78, swt_pkg::CH_BSLASH,
                swt_pkg::CH_CR, swt_pkg::CH_LF, 8'h79, swt_pkg::CH_BSLASH};
    flush_cmd(1'b0, 1'b0);
    // unclosed ANSI quote ending on a backslash
    cmd_buf = '{swt_pkg::CH_DOLLAR, swt_pkg::CH_SQUOTE, 8'h61, swt_pkg::CH_BSLASH};
    flush_cmd(1'b0, 1'b0);
    // trailing dollar
    cmd_buf = '{8'h7A, swt_pkg::CH_DOLLAR};
    flush_cmd(1'b0, 1'b0);
    add_drain();

    while (total_bytes < 23 + RANDOM_BYTES) begin
      build_random_cmd();
      if ($urandom_range(0, 11) == 0) begin
        add_drain();
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes || beats_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d commands sent, %0d token beats checked, %0d errors",
             bytes_taken, cmd_count, beats_seen, errs);
    $display("covered quoting, escapes, continuations, cut commands, stalls and a long hold-off");
    if (errs == 0 && beats_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
